// ===== design/prvc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prvc_pkg
// Shared types and constants for the plateau ridge/valley counter.
// ----------------------------------------------------------------------------
package prvc_pkg;

  typedef enum logic [9:0] {
    S_LOAD   = 10'b00_0000_0001,
    S_CHK_RD = 10'b00_0000_0010,
    S_CHK_EV = 10'b00_0000_0100,
    S_SCN_RD = 10'b00_0000_1000,
    S_SCN_EV = 10'b00_0001_0000,
    S_POP    = 10'b00_0010_0000,
    S_POP_W  = 10'b00_0100_0000,
    S_NB     = 10'b00_1000_0000,
    S_NB_EV  = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_e;

  typedef enum logic [1:0] {
    ST_ZERO = 2'd0,
    ST_DEC  = 2'd1,
    ST_INC  = 2'd2
  } step_e;

  localparam int unsigned CountW = 17;
  localparam int unsigned ExtW   = 31;
  localparam logic [ExtW-1:0] MinReset = 31'h7FFF_FFFF;

  // row offsets {-1,-1,0,1,1,1,0,-1}
  function automatic step_e row_step(input logic [2:0] k);
    step_e s;
    case (k)
      3'd0, 3'd1, 3'd7: s = ST_DEC;
      3'd3, 3'd4, 3'd5: s = ST_INC;
      default:          s = ST_ZERO;
    endcase
    return s;
  endfunction

  // column offsets {0,1,1,1,0,-1,-1,-1}
  function automatic step_e col_step(input logic [2:0] k);
    step_e s;
    case (k)
      3'd1, 3'd2, 3'd3: s = ST_INC;
      3'd5, 3'd6, 3'd7: s = ST_DEC;
      default:          s = ST_ZERO;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== design/plateau_ridge_valley_count.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plateau_ridge_valley_count
// Counts 8-connected regional maxima (ridges) and minima (valleys) of a grid.
// ----------------------------------------------------------------------------
// Heights are taken one item per cycle while loading, in row-major order,
// into a single-port height RAM addressed by {row, column}. After the last
// cell the block reads every cell to check for a uniform grid (clearing the
// visited RAM as it goes), scans the cells for unvisited seeds, and for
// each flooded cell pops it from the stack and checks each of its eight
// neighbours, reading those inside the grid; all this is bound by the
// one-read-per-cycle height RAM. Finally it hands the result over. New
// heights are refused until the sweep finishes and the output register is
// free; the result then sits in that register while loading goes on.
module plateau_ridge_valley_count
  import prvc_pkg::*;
#(
  parameter int unsigned MAX_SIDE    = 256,
  parameter int unsigned HEIGHT_BITS = 30
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [8:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [29:0] height_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [16:0]      ridge_count_o,
  output logic [16:0]      valley_count_o
);

  localparam int unsigned RB    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned AW    = 2 * RB;
  localparam int unsigned CELLS = MAX_SIDE * MAX_SIDE;
  localparam int unsigned TW    = $clog2(CELLS + 1);
  localparam int unsigned HB    = HEIGHT_BITS;
  localparam logic [RB-1:0] SideMaxM1 = RB'(MAX_SIDE - 1);

  state_e state_q, state_d;
  logic [8:0]    side_q;
  logic [RB-1:0] side_m1;
  logic [RB-1:0] lr_q, lr_d, lc_q, lc_d;
  logic [RB-1:0] sr_q, sr_d, sc_q, sc_d;
  logic [RB-1:0] cr_q, cr_d, cc_q, cc_d;
  logic [AW-1:0] nb_q, nb_d;
  logic [2:0]    k_q, k_d;
  logic [TW-1:0] top_q, top_d;
  logic [HB-1:0] level_q, level_d;
  logic          uni_q, uni_d;
  logic [ExtW-1:0] min_q, min_d, max_q, max_d;
  logic [CountW-1:0] ridge_q, ridge_d, valley_q, valley_d;
  logic          out_valid_q, out_valid_d;
  logic [CountW-1:0] ridge_o_q, ridge_o_d, valley_o_q, valley_o_d;

  logic [AW-1:0] h_addr, v_addr, s_addr;
  logic          h_we, v_we, v_wd, s_we;
  logic [AW-1:0] s_wd;
  logic [HB-1:0] h_rd;
  logic [0:0]    v_rd;
  logic [AW-1:0] s_rd;

  logic          in_acc, scan_last;
  logic [RB-1:0] nr, nc;
  logic          nb_ok;
  logic [ExtW-1:0] h_ext, lvl_ext;

  always_comb begin
    if (side_q == 9'd0) begin
      side_m1 = '0;
    end else if (32'(side_q) > 32'(MAX_SIDE)) begin
      side_m1 = SideMaxM1;
    end else begin
      side_m1 = RB'(32'(side_q) - 32'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= 9'd1;
    end else if (cfg_we_i) begin
      side_q <= (cfg_wdata_i == 9'd0) ? 9'd1 : cfg_wdata_i;
    end
  end

  assign in_ready_o = (state_q == S_LOAD);
  assign in_acc     = in_valid_i && in_ready_o;
  assign scan_last  = (sr_q == side_m1) && (sc_q == side_m1);
  assign h_ext      = ExtW'(h_rd);
  assign lvl_ext    = ExtW'(level_q);

  // neighbour of the popped cell for direction k
  always_comb begin
    nb_ok = 1'b1;
    nr    = cr_q;
    nc    = cc_q;
    case (row_step(k_q))
      ST_DEC: begin
        nb_ok = (cr_q != '0);
        nr    = cr_q - RB'(1);
      end
      ST_INC: begin
        nb_ok = (cr_q != side_m1);
        nr    = cr_q + RB'(1);
      end
      default: nr = cr_q;
    endcase
    case (col_step(k_q))
      ST_DEC: begin
        nb_ok = nb_ok && (cc_q != '0);
        nc    = cc_q - RB'(1);
      end
      ST_INC: begin
        nb_ok = nb_ok && (cc_q != side_m1);
        nc    = cc_q + RB'(1);
      end
      default: nc = cc_q;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    lr_d       = lr_q;
    lc_d       = lc_q;
    sr_d       = sr_q;
    sc_d       = sc_q;
    cr_d       = cr_q;
    cc_d       = cc_q;
    nb_d       = nb_q;
    k_d        = k_q;
    top_d      = top_q;
    level_d    = level_q;
    uni_d      = uni_q;
    min_d      = min_q;
    max_d      = max_q;
    ridge_d    = ridge_q;
    valley_d   = valley_q;
    ridge_o_d  = ridge_o_q;
    valley_o_d = valley_o_q;
    out_valid_d = out_valid_q && !out_ready_i;
    h_addr = '0;
    h_we   = 1'b0;
    v_addr = '0;
    v_we   = 1'b0;
    v_wd   = 1'b0;
    s_addr = '0;
    s_we   = 1'b0;
    s_wd   = '0;

    case (state_q)
      S_LOAD: begin
        h_addr = {lr_q, lc_q};
        h_we   = in_acc;
        if (cfg_we_i) begin
          lr_d = '0;
          lc_d = '0;
        end else if (in_acc) begin
          if (lc_q == side_m1) begin
            lc_d = '0;
            if (lr_q == side_m1) begin
              lr_d    = '0;
              sr_d    = '0;
              sc_d    = '0;
              uni_d   = 1'b1;
              state_d = S_CHK_RD;
            end else begin
              lr_d = lr_q + RB'(1);
            end
          end else begin
            lc_d = lc_q + RB'(1);
          end
        end
      end
      S_CHK_RD: begin
        h_addr  = {sr_q, sc_q};
        v_addr  = {sr_q, sc_q};
        v_we    = 1'b1;
        state_d = S_CHK_EV;
      end
      S_CHK_EV: begin
        if (sr_q == '0 && sc_q == '0) begin
          level_d = h_rd;
        end else if (h_rd != level_q) begin
          uni_d = 1'b0;
        end
        if (scan_last) begin
          sr_d = '0;
          sc_d = '0;
          if (uni_d) begin
            ridge_d  = CountW'(1);
            valley_d = CountW'(1);
            state_d  = S_DONE;
          end else begin
            ridge_d  = '0;
            valley_d = '0;
            state_d  = S_SCN_RD;
          end
        end else begin
          if (sc_q == side_m1) begin
            sc_d = '0;
            sr_d = sr_q + RB'(1);
          end else begin
            sc_d = sc_q + RB'(1);
          end
          state_d = S_CHK_RD;
        end
      end
      S_SCN_RD: begin
        h_addr  = {sr_q, sc_q};
        v_addr  = {sr_q, sc_q};
        state_d = S_SCN_EV;
      end
      S_SCN_EV: begin
        if (v_rd[0]) begin
          if (scan_last) begin
            state_d = S_DONE;
          end else begin
            if (sc_q == side_m1) begin
              sc_d = '0;
              sr_d = sr_q + RB'(1);
            end else begin
              sc_d = sc_q + RB'(1);
            end
            state_d = S_SCN_RD;
          end
        end else begin
          level_d = h_rd;
          min_d   = MinReset;
          max_d   = '0;
          v_addr  = {sr_q, sc_q};
          v_we    = 1'b1;
          v_wd    = 1'b1;
          s_addr  = '0;
          s_we    = 1'b1;
          s_wd    = {sr_q, sc_q};
          top_d   = TW'(1);
          state_d = S_POP;
        end
      end
      S_POP: begin
        if (top_q == '0) begin
          // plateau done: classify it
          if (!(lvl_ext < max_q && lvl_ext > min_q)) begin
            if (lvl_ext < max_q) begin
              valley_d = valley_q + CountW'(1);
            end else begin
              ridge_d = ridge_q + CountW'(1);
            end
          end
          if (scan_last) begin
            state_d = S_DONE;
          end else begin
            if (sc_q == side_m1) begin
              sc_d = '0;
              sr_d = sr_q + RB'(1);
            end else begin
              sc_d = sc_q + RB'(1);
            end
            state_d = S_SCN_RD;
          end
        end else begin
          top_d   = top_q - TW'(1);
          s_addr  = AW'(top_q - TW'(1));
          state_d = S_POP_W;
        end
      end
      S_POP_W: begin
        cr_d    = s_rd[AW-1:RB];
        cc_d    = s_rd[RB-1:0];
        k_d     = '0;
        state_d = S_NB;
      end
      S_NB: begin
        nb_d   = {nr, nc};
        h_addr = {nr, nc};
        v_addr = {nr, nc};
        if (nb_ok) begin
          state_d = S_NB_EV;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = (k_q == 3'd7) ? S_POP : S_NB;
        end
      end
      S_NB_EV: begin
        if (h_rd != level_q) begin
          if (h_ext < min_q) begin
            min_d = h_ext;
          end
          if (h_ext > max_q) begin
            max_d = h_ext;
          end
        end else if (!v_rd[0] && 32'(top_q) < CELLS) begin
          v_addr = nb_q;
          v_we   = 1'b1;
          v_wd   = 1'b1;
          s_addr = AW'(top_q);
          s_we   = 1'b1;
          s_wd   = nb_q;
          top_d  = top_q + TW'(1);
        end
        k_d     = k_q + 3'd1;
        state_d = (k_q == 3'd7) ? S_POP : S_NB;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          ridge_o_d   = ridge_q;
          valley_o_d  = valley_q;
          out_valid_d = 1'b1;
          state_d     = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      lr_q        <= '0;
      lc_q        <= '0;
      sr_q        <= '0;
      sc_q        <= '0;
      k_q         <= '0;
      top_q       <= '0;
      uni_q       <= 1'b0;
      min_q       <= MinReset;
      max_q       <= '0;
      ridge_q     <= '0;
      valley_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lr_q        <= lr_d;
      lc_q        <= lc_d;
      sr_q        <= sr_d;
      sc_q        <= sc_d;
      k_q         <= k_d;
      top_q       <= top_d;
      uni_q       <= uni_d;
      min_q       <= min_d;
      max_q       <= max_d;
      ridge_q     <= ridge_d;
      valley_q    <= valley_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cr_q       <= cr_d;
    cc_q       <= cc_d;
    nb_q       <= nb_d;
    level_q    <= level_d;
    ridge_o_q  <= ridge_o_d;
    valley_o_q <= valley_o_d;
  end

  prvc_ram #(.AW(AW), .DW(HB)) u_height (
    .clk_i   (clk_i),
    .addr_i  (h_addr),
    .we_i    (h_we),
    .wdata_i (height_i[HB-1:0]),
    .rdata_o (h_rd)
  );

  prvc_ram #(.AW(AW), .DW(1)) u_visited (
    .clk_i   (clk_i),
    .addr_i  (v_addr),
    .we_i    (v_we),
    .wdata_i (v_wd),
    .rdata_o (v_rd)
  );

  prvc_ram #(.AW(AW), .DW(AW)) u_stack (
    .clk_i   (clk_i),
    .addr_i  (s_addr),
    .we_i    (s_we),
    .wdata_i (s_wd),
    .rdata_o (s_rd)
  );

  assign out_valid_o    = out_valid_q;
  assign ridge_count_o  = ridge_o_q;
  assign valley_count_o = valley_o_q;

endmodule
`default_nettype wire

// ===== design/prvc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prvc_ram
// Single-port synchronous RAM, registered read data, read-first.
// ----------------------------------------------------------------------------
module prvc_ram #(
  parameter int unsigned AW = 16,
  parameter int unsigned DW = 30
) (
  input  wire logic          clk_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic          we_i,
  input  wire logic [DW-1:0] wdata_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule
`default_nettype wire

// ===== tb/sv/plateau_ridge_valley_count_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plateau_ridge_valley_count_tb
// Feeds height grids of assorted sizes through the valid/ready channel and
// compares every ridge/valley result against a behavioural flood-fill count.
// ----------------------------------------------------------------------------
module plateau_ridge_valley_count_tb;
  import prvc_pkg::*;

  localparam int unsigned CellMax  = 65536;
  localparam int unsigned SideMax  = 256;
  localparam logic [29:0] HeightMax = 30'h3FFF_FFFF;
  localparam int unsigned IdleCfg  = 40;

  typedef enum logic {
    PEND_HEIGHT,
    PEND_SIDE
  } pend_kind_e;

  typedef struct packed {
    pend_kind_e  kind;
    logic [29:0] value;
  } pend_t;

  typedef struct packed {
    logic [16:0] ridges;
    logic [16:0] valleys;
  } count_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [8:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [29:0] height_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [16:0] ridge_count_o;
  logic [16:0] valley_count_o;

  plateau_ridge_valley_count uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .height_i       (height_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .ridge_count_o  (ridge_count_o),
    .valley_count_o (valley_count_o)
  );

  pend_t  pend_q[$];
  count_t counts_q[$];
  int     errors;
  int     results_seen;

  // predictor state
  logic [8:0]  side_reg;
  int          cells_loaded;
  logic [29:0] grid_h[CellMax];
  bit          seen_map[CellMax];

  logic in_fire, out_fire, cfg_fire;
  int   quiet;
  int   gap, hold;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic int side_eff();
    if (side_reg == 9'd0) return 1;
    if (side_reg > SideMax) return SideMax;
    return int'(side_reg);
  endfunction

  function automatic count_t count_plateaus(input int side);
    count_t res;
    int     total, cur, rr, cc, nr, nc, nb;
    longint lvl, h, lo, hi;
    bit     uniform;
    int     stk[$];
    total = side * side;
    res = '0;
    uniform = 1'b1;
    for (int i = 1; i < total; i++)
      if (grid_h[i] != grid_h[0]) uniform = 1'b0;
    if (uniform) begin
      res.ridges = 17'd1;
      res.valleys = 17'd1;
      return res;
    end
    for (int i = 0; i < total; i++) seen_map[i] = 1'b0;
    for (int i = 0; i < total; i++) begin
      if (seen_map[i]) continue;
      lo = 64'h7FFF_FFFF;
      hi = 0;
      lvl = grid_h[i];
      seen_map[i] = 1'b1;
      stk.insert(stk.size(), i);
      while (stk.size() > 0) begin
        cur = stk.pop_back();
        rr = cur / side;
        cc = cur % side;
        for (int dr = -1; dr <= 1; dr++)
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr == 0 && dc == 0) continue;
            nr = rr + dr;
            nc = cc + dc;
            if (nr < 0 || nc < 0 || nr >= side || nc >= side) continue;
            nb = nr * side + nc;
            h = grid_h[nb];
            if (h != lvl) begin
              if (h < lo) lo = h;
              if (h > hi) hi = h;
            end else if (!seen_map[nb]) begin
              seen_map[nb] = 1'b1;
              stk.insert(stk.size(), nb);
            end
          end
      end
      if (lvl < hi && lvl > lo) continue;
      if (lvl < hi) res.valleys++;
      else res.ridges++;
    end
    return res;
  endfunction

  task automatic accept_height(input logic [29:0] h);
    int total;
    total = side_eff() * side_eff();
    if (cells_loaded >= total) cells_loaded = 0;
    grid_h[cells_loaded] = h;
    cells_loaded++;
    if (cells_loaded == total) begin
      cells_loaded = 0;
      counts_q.insert(counts_q.size(), count_plateaus(total == 1 ? 1 : side_eff()));
    end
  endtask

  task automatic push_side(input int s);
    pend_q.insert(pend_q.size(), '{PEND_SIDE, 30'(s)});
  endtask

  task automatic push_h(input logic [29:0] h);
    pend_q.insert(pend_q.size(), '{PEND_HEIGHT, h});
  endtask

  function automatic logic [29:0] rand_height(input int mode);
    case (mode)
      0:       return 30'($urandom_range(0, 3));
      1:       return 30'($urandom);
      2:       return $urandom_range(0, 1) ? HeightMax : 30'd0;
      default: return HeightMax - 30'($urandom_range(0, 2));
    endcase
  endfunction

  // stimulus
  initial begin
    int s, n, mode, items, part;
    errors = 0;
    // reset side is 1: one cell gives a uniform grid
    push_h(30'd0);
    push_side(0);                    // zero side acts as 1
    push_h(HeightMax);
    push_side(2);                    // uniform 2x2
    repeat (4) push_h(30'd7);
    push_side(3);                    // single peak in the middle
    for (int i = 0; i < 9; i++) push_h(i == 4 ? HeightMax : 30'd5);
    for (int i = 0; i < 9; i++) push_h(i == 4 ? 30'd0 : 30'd5);   // single pit
    repeat (4) push_h(30'd1);        // partial grid, restarted by side write
    push_side(511);                  // beyond max: acts as max side
    for (int i = 0; i < 10; i++) push_h(30'($urandom));
    push_side(SideMax);
    for (int i = 0; i < 10; i++) push_h(30'($urandom));
    push_side(1);
    push_h(30'h2AAA_AAAA);
    push_h(30'h1555_5555);

    items = 0;
    while (items < 400) begin
      s = $urandom_range(1, 6);
      push_side(s);
      n = $urandom_range(1, 4);
      for (int g = 0; g < n; g++) begin
        mode = $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3);
        for (int i = 0; i < s * s; i++) push_h(rand_height(mode));
        items += s * s;
      end
      if ($urandom_range(0, 7) == 0) begin
        // broken grid: a few cells then a side write
        part = $urandom_range(1, 3);
        for (int i = 0; i < part; i++) push_h(rand_height(1));
        items += part;
      end
    end

    @(negedge clk_i);
    while (pend_q.size() > 0 || in_valid_i || counts_q.size() > 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // reset
  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  initial begin
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    height_i = '0;
    out_ready_i = 1'b0;
    side_reg = 9'd1;
    cells_loaded = 0;
    results_seen = 0;
    gap = 0;
    hold = 0;
  end

  // handshake capture and monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
      out_fire <= 1'b0;
      cfg_fire <= 1'b0;
      quiet <= 0;
    end else begin
      in_fire <= in_valid_i && in_ready_o;
      out_fire <= out_valid_o && out_ready_i;
      cfg_fire <= cfg_we_i;
      if (in_valid_i && in_ready_o) accept_height(height_i);
      if (out_valid_o && out_ready_i) begin
        if (counts_q.size() == 0) begin
          report($sformatf("unexpected result %0d/%0d", ridge_count_o, valley_count_o));
        end else begin
          count_t e;
          e = counts_q.pop_front();
          if (ridge_count_o !== e.ridges)
            report($sformatf("ridges %0d, want %0d", ridge_count_o, e.ridges));
          if (valley_count_o !== e.valleys)
            report($sformatf("valleys %0d, want %0d", valley_count_o, e.valleys));
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
        quiet <= 0;
      else
        quiet <= quiet + 1;
    end
  end

  // driver
  always @(negedge clk_i) begin
    logic        v_next, we_next;
    logic [29:0] h_next;
    logic [8:0]  w_next;
    if (rst_ni) begin
      v_next = in_valid_i && !in_fire;
      h_next = height_i;
      we_next = 1'b0;
      w_next = cfg_wdata_i;
      if (!v_next) begin
        if (gap > 0) begin
          gap--;
        end else if (pend_q.size() > 0) begin
          if (pend_q[0].kind == PEND_SIDE) begin
            // side writes only once the block has drained
            if (counts_q.size() == 0 && quiet >= IdleCfg && !cfg_we_i && !cfg_fire) begin
              we_next = 1'b1;
              w_next = pend_q[0].value[8:0];
              side_reg = pend_q[0].value[8:0];
              cells_loaded = 0;
              void'(pend_q.pop_front());
            end
          end else begin
            v_next = 1'b1;
            h_next = pend_q[0].value;
            void'(pend_q.pop_front());
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
          end
        end
      end
      in_valid_i <= v_next;
      height_i <= h_next;
      cfg_we_i <= we_next;
      cfg_wdata_i <= w_next;
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_fire) begin
        results_seen++;
        // one long hold-off so the block backs up onto its input
        if (results_seen == 12) hold = 3000;
        else hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

endmodule

// ===== filelist.f =====
design/prvc_pkg.sv
design/prvc_ram.sv
design/plateau_ridge_valley_count.sv
tb/sv/plateau_ridge_valley_count_tb.sv
